/* rtl/rcsa_pkg.sv */
// ----------------------------------------------------------------------------
// rcsa_pkg
// Shared types and constants of the reference-counted slot allocator.
// ----------------------------------------------------------------------------
package rcsa_pkg;

  localparam int SLOTS_DEFAULT      = 1024;
  localparam int COUNT_BITS_DEFAULT = 16;
  localparam int SLOT_FIELD_W       = 10;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_ADD_REF = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_NOP     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_t;

  typedef struct packed {
    func_t                   func;
    logic [SLOT_FIELD_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_FIELD_W-1:0] granted_slot;
    logic                    freed;
    status_t                 status;
  } rsp_t;

endpackage

/* rtl/rcsa_ram.sv */
// ----------------------------------------------------------------------------
// rcsa_ram
// Slot word memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rcsa_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = 17
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/rcsa_ctrl.sv */
// ----------------------------------------------------------------------------
// rcsa_ctrl
// Request sequencer: issue the slot word read, then modify, write back and
// register the response. Holds the free list head and the fresh counter.
// ----------------------------------------------------------------------------
module rcsa_ctrl #(
  parameter int SLOTS      = 1024,
  parameter int COUNT_BITS = 16,
  parameter int SLOT_W     = $clog2(SLOTS),
  parameter int WORD_W     = (COUNT_BITS > SLOT_W + 1) ? COUNT_BITS : SLOT_W + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  rcsa_pkg::req_t     req,
  input  logic               req_valid,
  output logic               req_stall,
  output rcsa_pkg::rsp_t     rsp,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic               rd_en,
  output logic [SLOT_W-1:0]  rd_addr,
  input  logic [WORD_W:0]    rd_data,
  output logic               wr_en,
  output logic [SLOT_W-1:0]  wr_addr,
  output logic [WORD_W:0]    wr_data
);

  import rcsa_pkg::*;

  localparam int CW = (SLOT_W + 1 > SLOT_FIELD_W) ? SLOT_W + 1 : SLOT_FIELD_W;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                  state;
  func_t                   func_q;
  logic [SLOT_FIELD_W-1:0] slot_q;
  logic [SLOT_W-1:0]       free_head;
  logic                    free_nonempty;
  logic [SLOT_W:0]         fresh_count;

  logic [SLOT_W-1:0]       head_next;
  logic                    nonempty_next;
  logic [SLOT_W:0]         fresh_next;
  rsp_t                    rsp_next;
  logic                    wr_req;

  logic [CW-1:0]           in_slot_ext;
  logic [CW-1:0]           slot_ext;
  logic [CW-1:0]           fresh_ext;
  logic [CW-1:0]           idx_ext;
  logic [SLOT_W-1:0]       slot_addr;
  logic [SLOT_W-1:0]       idx;
  logic [COUNT_BITS-1:0]   cnt;
  logic                    live;
  logic                    done;
  logic                    accept;

  assign req_stall   = (state != S_IDLE);
  assign accept      = req_valid && !req_stall;
  assign done        = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  assign in_slot_ext = CW'(req.slot);
  assign slot_ext    = CW'(slot_q);
  assign fresh_ext   = CW'(fresh_count);
  assign slot_addr   = slot_ext[SLOT_W-1:0];

  assign rd_en       = accept;
  assign rd_addr     = (req.func == FUNC_ALLOC) ? free_head : in_slot_ext[SLOT_W-1:0];

  assign cnt         = rd_data[COUNT_BITS-1:0];
  assign live        = rd_data[WORD_W] && (slot_ext < fresh_ext);

  assign wr_en       = done && wr_req;

  always_comb begin
    head_next     = free_head;
    nonempty_next = free_nonempty;
    fresh_next    = fresh_count;
    wr_req        = 1'b0;
    wr_addr       = slot_addr;
    wr_data       = {1'b1, WORD_W'(cnt)};
    idx           = slot_addr;
    rsp_next      = '{granted_slot: slot_q, freed: 1'b0, status: ST_OK};
    unique case (func_q)
      FUNC_ALLOC: begin
        if (free_nonempty) begin
          idx           = free_head;
          head_next     = rd_data[SLOT_W-1:0];
          nonempty_next = rd_data[SLOT_W];
        end else begin
          idx        = fresh_count[SLOT_W-1:0];
          fresh_next = fresh_count + 1'b1;
        end
        if (free_nonempty || (fresh_ext < SLOTS_C)) begin
          wr_req                = 1'b1;
          wr_addr               = idx;
          wr_data               = {1'b1, WORD_W'(1'b0)};
        end else begin
          fresh_next      = fresh_count;
          rsp_next.status = ST_FULL;
        end
      end
      FUNC_ADD_REF: begin
        if (!live) begin
          rsp_next.status = ST_NOT_LIVE;
        end else begin
          wr_req  = 1'b1;
          wr_data = {1'b1, WORD_W'((cnt == COUNT_MAX) ? cnt : cnt + 1'b1)};
        end
      end
      FUNC_RELEASE: begin
        if (!live) begin
          rsp_next.status = ST_NOT_LIVE;
        end else if (cnt[COUNT_BITS-1:1] == '0) begin
          wr_req         = 1'b1;
          wr_data        = {1'b0, WORD_W'({free_nonempty, free_head})};
          head_next      = slot_addr;
          nonempty_next  = 1'b1;
          rsp_next.freed = 1'b1;
        end else begin
          wr_req  = 1'b1;
          wr_data = {1'b1, WORD_W'(cnt - 1'b1)};
        end
      end
      FUNC_NOP: begin
      end
      default: begin
      end
    endcase
    idx_ext = CW'(idx);
    if (func_q == FUNC_ALLOC && rsp_next.status == ST_OK) begin
      rsp_next.granted_slot = idx_ext[SLOT_FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rsp_valid     <= 1'b0;
      free_head     <= '0;
      free_nonempty <= 1'b0;
      fresh_count   <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && !done) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (done) begin
            state         <= S_IDLE;
            rsp_valid     <= 1'b1;
            free_head     <= head_next;
            free_nonempty <= nonempty_next;
            fresh_count   <= fresh_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
    if (accept) begin
      func_q <= req.func;
      slot_q <= req.slot;
    end
    if (done) begin
      rsp <= rsp_next;
    end
  end

endmodule

/* rtl/refcounted_slot_allocator.sv */
// ----------------------------------------------------------------------------
// refcounted_slot_allocator
// Slot allocator with a free list and per-slot reference counts.
// ----------------------------------------------------------------------------
// The slot word (the free list head on allocate, the addressed slot otherwise)
// is read from the slot memory as a request is taken; in S_EXEC it is
// modified and written back and the response register is loaded. A new
// request is taken only once the last one is through; a held response
// delays the write back until the output register frees. The live flag sits
// in the slot word and counts only below the fresh counter, so reset needs no
// clearing pass and the block is ready on the cycle after it.
// ----------------------------------------------------------------------------
module refcounted_slot_allocator #(
  parameter int SLOTS      = rcsa_pkg::SLOTS_DEFAULT,
  parameter int COUNT_BITS = rcsa_pkg::COUNT_BITS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  rcsa_pkg::req_t req,
  input  logic           req_valid,
  output logic           req_stall,
  output rcsa_pkg::rsp_t rsp,
  output logic           rsp_valid,
  input  logic           rsp_stall
);

  import rcsa_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int WORD_W = (COUNT_BITS > SLOT_W + 1) ? COUNT_BITS : SLOT_W + 1;

  logic              rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [WORD_W:0]   rd_data;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [WORD_W:0]   wr_data;

  rcsa_ctrl #(
    .SLOTS      (SLOTS),
    .COUNT_BITS (COUNT_BITS),
    .SLOT_W     (SLOT_W),
    .WORD_W     (WORD_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  rcsa_ram #(
    .DEPTH  (SLOTS),
    .ADDR_W (SLOT_W),
    .DATA_W (WORD_W + 1)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

/* rtl/rcsa_checker.sv */
// ----------------------------------------------------------------------------
// rcsa_checker
// Port-level checks of the slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module rcsa_checker (
  input logic           clk,
  input logic           rst,
  input rcsa_pkg::req_t req,
  input logic           req_valid,
  input logic           req_stall,
  input rcsa_pkg::rsp_t rsp,
  input logic           rsp_valid,
  input logic           rsp_stall
);

  import rcsa_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while another is in work");

  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response without a request in work");

  a_freed_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.freed) |-> (rsp.status == ST_OK))
    else $error("freed beat with error status");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response beat changed");

endmodule

bind refcounted_slot_allocator rcsa_checker u_rcsa_checker (
  .clk       (clk),
  .rst       (rst),
  .req       (req),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp       (rsp),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall)
);

/* tb/sv/tb_refcounted_slot_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_refcounted_slot_allocator
// Self-checking bench for the reference-counted slot allocator.
// ----------------------------------------------------------------------------
// A directed table hits the not-live errors, the unused function code and the
// first grants. One slot then takes a short run of add-refs and releases, and
// the table is filled until allocate reports full. A random phase alternates
// between filling and draining the table, mostly on live slots with some
// noise. Every response is checked field by field: typed directed rows against
// the table, the rest against a local copy of the free list, the counts and the
// live map. The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_refcounted_slot_allocator;
  import rcsa_pkg::*;

  localparam int          SLOTS     = SLOTS_DEFAULT;
  localparam logic [31:0] COUNT_MAX = (32'h1 << COUNT_BITS_DEFAULT) - 32'h1;
  localparam int          RANDOM_BEATS = 550;
  localparam int          REF_BEATS    = 8;
  localparam int          MAX_PRINTS   = 50;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PATTERN, STALL_RUNS} stall_mode_t;

  typedef struct packed {
    req_t r;
    logic typed;
    rsp_t exp;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{'{FUNC_RELEASE, 10'd0},     1'b1, '{10'd0,     1'b0, ST_NOT_LIVE}},
    '{'{FUNC_ADD_REF, 10'd1023},  1'b1, '{10'd1023,  1'b0, ST_NOT_LIVE}},
    '{'{FUNC_ADD_REF, 10'h2AA},   1'b1, '{10'h2AA,   1'b0, ST_NOT_LIVE}},
    '{'{FUNC_RELEASE, 10'h155},   1'b1, '{10'h155,   1'b0, ST_NOT_LIVE}},
    '{'{FUNC_NOP,     10'd1023},  1'b1, '{10'd1023,  1'b0, ST_OK}},
    '{'{FUNC_NOP,     10'd0},     1'b1, '{10'd0,     1'b0, ST_OK}},
    '{'{FUNC_ALLOC,   10'd1023},  1'b1, '{10'd0,     1'b0, ST_OK}},
    '{'{FUNC_ALLOC,   10'd0},     1'b1, '{10'd1,     1'b0, ST_OK}},
    '{'{FUNC_ALLOC,   10'h155},   1'b1, '{10'd2,     1'b0, ST_OK}},
    '{'{FUNC_ADD_REF, 10'd0},     1'b0, '0},
    '{'{FUNC_ADD_REF, 10'd0},     1'b0, '0},
    '{'{FUNC_RELEASE, 10'd0},     1'b0, '0},
    '{'{FUNC_RELEASE, 10'd0},     1'b0, '0},
    '{'{FUNC_RELEASE, 10'd0},     1'b1, '{10'd0,     1'b0, ST_NOT_LIVE}},
    '{'{FUNC_ADD_REF, 10'd0},     1'b1, '{10'd0,     1'b0, ST_NOT_LIVE}},
    '{'{FUNC_RELEASE, 10'd1},     1'b0, '0},
    '{'{FUNC_ALLOC,   10'd0},     1'b0, '0},
    '{'{FUNC_ALLOC,   10'd0},     1'b0, '0},
    '{'{FUNC_ALLOC,   10'd0},     1'b0, '0},
    '{'{FUNC_RELEASE, 10'd2},     1'b0, '0},
    '{'{FUNC_RELEASE, 10'd0},     1'b0, '0},
    '{'{FUNC_RELEASE, 10'd1},     1'b0, '0},
    '{'{FUNC_ALLOC,   10'd0},     1'b0, '0},
    '{'{FUNC_ALLOC,   10'd0},     1'b0, '0},
    '{'{FUNC_ALLOC,   10'd0},     1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  req_t req = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  rsp_t rsp;
  logic rsp_valid;
  logic rsp_stall = 1'b0;

  refcounted_slot_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  initial begin
    #20_000_000;
    $display("tb_refcounted_slot_allocator NOT OK");
    $finish;
  end

  // slot table mirror
  logic [31:0] slot_word [SLOTS];
  bit          slot_live [SLOTS];
  logic [15:0] list_head = '0;
  bit          list_nonempty = 1'b0;
  int unsigned fresh_next = 0;
  int unsigned live_slots [$];

  rsp_t owed_rsp [$];
  int   n_errors = 0;
  int   n_beats = 0;
  int   n_checked = 0;
  int   n_grants = 0;
  int   n_full = 0;
  int   n_frees = 0;
  int   n_not_live = 0;
  int   n_saturated = 0;
  int   burst_left = 0;

  task automatic report_mismatch(input string msg);
    if (n_errors < MAX_PRINTS) begin
      $display("%0t: mismatch: %s", $realtime, msg);
    end
    n_errors++;
  endtask

  function automatic rsp_t serve_request(input req_t r);
    rsp_t        o;
    int unsigned idx;
    logic [31:0] w;
    logic [31:0] c;
    o.granted_slot = r.slot;
    o.freed        = 1'b0;
    o.status       = ST_OK;
    if (r.func == FUNC_ALLOC) begin
      if (list_nonempty) begin
        idx           = int'(list_head);
        w             = slot_word[idx];
        list_head     = w[15:0];
        list_nonempty = w[31];
      end else if (fresh_next < SLOTS) begin
        idx = fresh_next;
        fresh_next++;
      end else begin
        o.status = ST_FULL;
        n_full++;
        return o;
      end
      slot_word[idx] = '0;
      slot_live[idx] = 1'b1;
      live_slots.insert(live_slots.size(), idx);
      o.granted_slot = idx[SLOT_FIELD_W-1:0];
      n_grants++;
    end else if (r.func != FUNC_NOP) begin
      if (!slot_live[r.slot]) begin
        o.status = ST_NOT_LIVE;
        n_not_live++;
      end else begin
        c = slot_word[r.slot] & COUNT_MAX;
        if (r.func == FUNC_ADD_REF) begin
          if (c < COUNT_MAX) c++;
          else n_saturated++;
          slot_word[r.slot] = c;
        end else if (c <= 32'd1) begin
          w                 = 32'(list_head);
          w[31]             = list_nonempty;
          slot_word[r.slot] = w;
          list_head         = 16'(r.slot);
          list_nonempty     = 1'b1;
          slot_live[r.slot] = 1'b0;
          for (int i = 0; i < live_slots.size(); i++) begin
            if (live_slots[i] == r.slot) begin
              live_slots.delete(i);
              break;
            end
          end
          o.freed = 1'b1;
          n_frees++;
        end else begin
          slot_word[r.slot] = c - 32'd1;
        end
      end
    end
    return o;
  endfunction

  function automatic req_t pick_request(input bit filling);
    req_t        r;
    int unsigned roll;
    r.slot = SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
    r.func = FUNC_ALLOC;
    roll   = $urandom_range(0, 99);
    if (roll < 5) begin
      r.func = func_t'($urandom_range(0, 3));
      return r;
    end
    roll = $urandom_range(0, 99);
    if (live_slots.size() != 0 && roll >= (filling ? 55 : 25)) begin
      r.slot = SLOT_FIELD_W'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
      r.func = (roll < (filling ? 80 : 50)) ? FUNC_ADD_REF : FUNC_RELEASE;
    end
    return r;
  endfunction

  task automatic send_beat(input req_t r, input bit typed, input rsp_t typed_rsp);
    rsp_t p;
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
    burst_left--;
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    p = serve_request(r);
    owed_rsp.insert(owed_rsp.size(), typed ? typed_rsp : p);
    n_beats++;
  endtask

  // response stall pattern
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_left = 0;
  int unsigned run_left = 0;
  int unsigned cyc = 0;

  always @(posedge clk) begin
    cyc++;
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(64, 512);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE: rsp_stall <= 1'b0;
      STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
      STALL_PATTERN: rsp_stall <= ((cyc % 5) == 1) || ((cyc % 5) == 2);
      default: begin
        if (run_left == 0) begin
          rsp_stall <= ~rsp_stall;
          run_left = $urandom_range(1, 10);
        end else begin
          run_left--;
        end
      end
    endcase
  end

  always @(posedge clk) begin : check_rsp
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (owed_rsp.size() == 0) begin
        report_mismatch($sformatf("response with nothing owed, slot %0d status %0d",
                                  rsp.granted_slot, rsp.status));
      end else begin
        e = owed_rsp[0];
        owed_rsp.delete(0);
        n_checked++;
        if (rsp.granted_slot !== e.granted_slot)
          report_mismatch($sformatf("granted_slot %0d, want %0d",
                                    rsp.granted_slot, e.granted_slot));
        if (rsp.freed !== e.freed)
          report_mismatch($sformatf("freed %0b, want %0b (slot %0d)",
                                    rsp.freed, e.freed, e.granted_slot));
        if (rsp.status !== e.status)
          report_mismatch($sformatf("status %0d, want %0d (slot %0d)",
                                    rsp.status, e.status, e.granted_slot));
      end
    end
  end

  initial begin
    req_t r;
    int   k;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      send_beat(DIRECTED_ROWS[i].r, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].exp);
    end

    // raise the count of slot 3, then step it partly back down
    r.func = FUNC_ADD_REF;
    r.slot = 10'd3;
    repeat (REF_BEATS) send_beat(r, 1'b0, '0);
    r.func = FUNC_RELEASE;
    repeat (2) send_beat(r, 1'b0, '0);

    // fill the table, then ask for more
    while (fresh_next < SLOTS || list_nonempty) begin
      r.func = FUNC_ALLOC;
      r.slot = SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
      send_beat(r, 1'b0, '0);
    end
    repeat (3) begin
      r.func = FUNC_ALLOC;
      r.slot = SLOT_FIELD_W'($urandom_range(0, SLOTS - 1));
      send_beat(r, 1'b0, '0);
    end

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      send_beat(pick_request(((i / 200) % 2) == 1), 1'b0, '0);
    end
    req_valid <= 1'b0;

    k = 0;
    while (owed_rsp.size() != 0 && k < 4000) begin
      @(posedge clk);
      k++;
    end
    if (owed_rsp.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", owed_rsp.size()));
    repeat (10) @(posedge clk);

    $display("sent %0d requests, checked %0d responses", n_beats, n_checked);
    $display("grants %0d, full %0d, frees %0d, not-live %0d, held at count limit %0d",
             n_grants, n_full, n_frees, n_not_live, n_saturated);
    if (n_errors == 0) begin
      $display("tb_refcounted_slot_allocator OK");
    end else begin
      $display("tb_refcounted_slot_allocator NOT OK");
    end
    $finish;
  end

endmodule
